[rtl/core/scp_pkg.sv]
// Shared types and constants for the serial command frame parser.
package scp_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned YEAR_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned COUNT_W  = 4;
  localparam int unsigned DATE_BYTES = 7;
  localparam int unsigned DATE_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE_MARKER  = 2'd2;

  // Configuration reset values.
  localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'hA5;
  localparam logic [BYTE_W-1:0] END_MARKER_RESET   = 8'h5A;
  localparam logic [BYTE_W-1:0] MODE_MARKER_RESET  = 8'h04;

  // Command codes and the fixed data byte of the short commands.
  localparam logic [BYTE_W-1:0] CMD_SET_CLOCK    = 8'h01;
  localparam logic [BYTE_W-1:0] CMD_CLEAR        = 8'h02;
  localparam logic [BYTE_W-1:0] CMD_FACTORY      = 8'h03;
  localparam logic [BYTE_W-1:0] SHORT_DATA_VALUE = 8'h01;

  // Body byte counts: seven date bytes then the checksum in a set-time frame,
  // one data byte then the checksum in a short frame.
  localparam logic [COUNT_W-1:0] SET_DATA_LAST  = 4'd7;
  localparam logic [COUNT_W-1:0] SET_TAIL_COUNT = 4'd8;
  localparam logic [COUNT_W-1:0] SHORT_SUM_COUNT  = 4'd1;
  localparam logic [COUNT_W-1:0] SHORT_TAIL_COUNT = 4'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_SET_OK       = 3'd0,
    ST_CLEAR        = 3'd1,
    ST_FACTORY      = 3'd2,
    ST_BAD_MODE     = 3'd3,
    ST_UNKNOWN_CMD  = 3'd4,
    ST_BAD_TAIL     = 3'd5,
    ST_BAD_CHECKSUM = 3'd6,
    ST_BAD_FRAMING  = 3'd7
  } status_t;

  typedef enum logic [4:0] {
    PH_HUNT       = 5'b00001,
    PH_MODE       = 5'b00010,
    PH_CMD        = 5'b00100,
    PH_SET_BODY   = 5'b01000,
    PH_SHORT_BODY = 5'b10000
  } phase_t;

endpackage

[rtl/core/serial_command_frame_parser.sv]
// Serial command frame parser: byte-wise frame grammar check with status result.
//
//   Channel   Direction  Handshake               Payload
//   cfg       in         cfg_wr                  cfg_index, cfg_data
//   input     in         in_valid / in_stall     rx_byte
//   result    out        out_valid / out_stall   status, year, month, day,
//                                                hour, minute, second
//
// One received byte is taken per clock cycle while in_stall is low. The byte
// is judged against the parse state in a single combinational step, and any
// result it finishes is loaded into the result register, so a result appears
// in the cycle after the transaction that completes the frame. in_stall is
// raised only while a result is held in the result register and the consumer
// stalls it; a result taken in the same cycle frees the register for the next one.
// Reset is synchronous and returns the parser to hunting for the start byte
// with the three markers at their default values.
module serial_command_frame_parser (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr,
  input  logic [scp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scp_pkg::BYTE_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [scp_pkg::BYTE_W-1:0]      rx_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [scp_pkg::STATUS_W-1:0]    status,
  output logic [scp_pkg::YEAR_W-1:0]      year,
  output logic [scp_pkg::BYTE_W-1:0]      month,
  output logic [scp_pkg::BYTE_W-1:0]      day,
  output logic [scp_pkg::BYTE_W-1:0]      hour,
  output logic [scp_pkg::BYTE_W-1:0]      minute,
  output logic [scp_pkg::BYTE_W-1:0]      second
);
  import scp_pkg::*;

  // Configuration registers.
  logic [BYTE_W-1:0] start_marker;
  logic [BYTE_W-1:0] end_marker;
  logic [BYTE_W-1:0] mode_marker;

  // Parse state.
  phase_t             phase, phase_next;
  logic [COUNT_W-1:0] bytes_seen, bytes_seen_next;
  logic [BYTE_W-1:0]  running_xor, running_xor_next;
  // Only clear versus factory reset matters once a short command is held.
  logic               cmd_clear, cmd_clear_next;
  logic [BYTE_W-1:0]  data_store [DATE_BYTES];

  logic               accept;
  logic               store_wr;
  logic [DATE_IDX_W-1:0] store_idx;
  logic               emit;
  status_t            emit_status;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= START_MARKER_RESET;
      end_marker   <= END_MARKER_RESET;
      mode_marker  <= MODE_MARKER_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_START_MARKER: start_marker <= cfg_data;
        REG_END_MARKER:   end_marker   <= cfg_data;
        REG_MODE_MARKER:  mode_marker  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next-state logic for one accepted byte. Every byte is judged only by the
  // phase it arrives in, so a marker value inside a frame is plain data.
  always_comb begin
    phase_next       = phase;
    bytes_seen_next  = bytes_seen;
    running_xor_next = running_xor;
    cmd_clear_next   = cmd_clear;
    store_wr         = 1'b0;
    store_idx        = bytes_seen[DATE_IDX_W-1:0];
    emit             = 1'b0;
    emit_status      = ST_SET_OK;

    if (accept) begin
      case (phase)
        PH_HUNT: begin
          if (rx_byte == start_marker) begin
            phase_next      = PH_MODE;
            bytes_seen_next = '0;
          end
        end
        PH_MODE: begin
          // A wrong mode byte is consumed here, not retried as a start byte.
          if (rx_byte != mode_marker) begin
            emit        = 1'b1;
            emit_status = ST_BAD_MODE;
          end else begin
            running_xor_next = rx_byte;
            phase_next       = PH_CMD;
          end
        end
        PH_CMD: begin
          running_xor_next = running_xor ^ rx_byte;
          bytes_seen_next  = '0;
          cmd_clear_next   = (rx_byte == CMD_CLEAR);
          if (rx_byte == CMD_SET_CLOCK) begin
            phase_next = PH_SET_BODY;
          end else if (rx_byte == CMD_CLEAR || rx_byte == CMD_FACTORY) begin
            phase_next = PH_SHORT_BODY;
          end else begin
            emit        = 1'b1;
            emit_status = ST_UNKNOWN_CMD;
          end
        end
        PH_SET_BODY: begin
          if (bytes_seen < SET_DATA_LAST) begin
            store_wr         = 1'b1;
            running_xor_next = running_xor ^ rx_byte;
            bytes_seen_next  = bytes_seen + 1'b1;
          end else if (bytes_seen == SET_DATA_LAST) begin
            // Folding the checksum in leaves zero when it matches.
            running_xor_next = running_xor ^ rx_byte;
            bytes_seen_next  = bytes_seen + 1'b1;
          end else begin
            emit = 1'b1;
            if (rx_byte != end_marker) begin
              emit_status = ST_BAD_TAIL;
            end else if (running_xor != '0) begin
              emit_status = ST_BAD_CHECKSUM;
            end else begin
              emit_status = ST_SET_OK;
            end
          end
        end
        PH_SHORT_BODY: begin
          if (bytes_seen == '0) begin
            store_wr         = 1'b1;
            store_idx        = '0;
            running_xor_next = running_xor ^ rx_byte;
            bytes_seen_next  = SHORT_SUM_COUNT;
          end else if (bytes_seen == SHORT_SUM_COUNT) begin
            running_xor_next = running_xor ^ rx_byte;
            bytes_seen_next  = SHORT_TAIL_COUNT;
          end else begin
            emit = 1'b1;
            if (data_store[0] != SHORT_DATA_VALUE || rx_byte != end_marker) begin
              emit_status = ST_BAD_FRAMING;
            end else if (running_xor != '0) begin
              emit_status = ST_BAD_CHECKSUM;
            end else if (cmd_clear) begin
              emit_status = ST_CLEAR;
            end else begin
              emit_status = ST_FACTORY;
            end
          end
        end
        default: begin
          phase_next      = PH_HUNT;
          bytes_seen_next = '0;
        end
      endcase

      // Every finished or failed frame sends the parser back to hunting.
      if (emit) begin
        phase_next      = PH_HUNT;
        bytes_seen_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      bytes_seen  <= '0;
      running_xor <= '0;
      cmd_clear   <= 1'b0;
    end else begin
      phase       <= phase_next;
      bytes_seen  <= bytes_seen_next;
      running_xor <= running_xor_next;
      cmd_clear   <= cmd_clear_next;
    end
  end

  // Captured data bytes need no reset: each is written earlier in the same
  // frame before it is read.
  always_ff @(posedge clk) begin
    if (store_wr) begin
      data_store[store_idx] <= rx_byte;
    end
  end

  // Result register. The date fields are zero for every status but set-time ok.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      status <= emit_status;
      if (emit_status == ST_SET_OK) begin
        year   <= {data_store[2], data_store[3]};
        month  <= data_store[1];
        day    <= data_store[0];
        hour   <= data_store[4];
        minute <= data_store[5];
        second <= data_store[6];
      end else begin
        year   <= '0;
        month  <= '0;
        day    <= '0;
        hour   <= '0;
        minute <= '0;
        second <= '0;
      end
    end
  end

  // A new result only appears after a byte transaction.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("result appeared without an input transaction");

  // While hunting the body byte count is always clear.
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HUNT) |-> (bytes_seen == '0))
    else $error("byte count not clear while hunting");

  // The body byte count stays within the frame length of each command type.
  assert property (@(posedge clk) disable iff (rst)
    ((phase == PH_SET_BODY) |-> (bytes_seen <= SET_TAIL_COUNT)) and
    ((phase == PH_SHORT_BODY) |-> (bytes_seen <= SHORT_TAIL_COUNT)))
    else $error("body byte count out of range");

  // Failed or short-command results carry no date.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_SET_OK) |->
      (year == '0 && month == '0 && day == '0 && hour == '0 &&
       minute == '0 && second == '0))
    else $error("date fields set on a result other than set-time ok");

endmodule
